[rtl/alu_with_math_ops_and_flags_top_macros.svh]
// Assertion macros for the ALU block.
`ifndef ALU_WITH_MATH_OPS_AND_FLAGS_TOP_MACROS_SVH
`define ALU_WITH_MATH_OPS_AND_FLAGS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock, disabled in reset.
`define AMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define AMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define AMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/amf_pkg.sv]
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types, operation codes and constant tables of the ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package amf_pkg;
	localparam int unsigned OpW   = 5;
	localparam int unsigned DataW = 32;
	localparam int unsigned ResW  = 64;
	localparam int unsigned QueueDepthDef = 4;

	localparam logic [OpW-1:0] OP_ADD = 5'd0, OP_SUB = 5'd1, OP_INC = 5'd2,
		OP_DEC = 5'd3, OP_MUL = 5'd4, OP_DIV = 5'd5, OP_SQR = 5'd6,
		OP_SQRT = 5'd7, OP_PASSA = 5'd8, OP_PASSB = 5'd9, OP_ZERO = 5'd10,
		OP_ONES = 5'd11, OP_LN = 5'd12, OP_LOG10 = 5'd13, OP_EXP = 5'd14,
		OP_OR = 5'd15, OP_AND = 5'd16, OP_XOR = 5'd17, OP_NOT = 5'd18,
		OP_SHR = 5'd19, OP_SHL = 5'd20;

	// Execution class chosen by the front end
	typedef enum logic [2:0] {
		CL_SIMPLE, CL_MUL, CL_DIV, CL_SQRT
	} op_class_t;

	typedef struct packed {
		op_class_t        cls;
		logic [OpW-1:0]   action;
		logic [DataW-1:0] operand_a;
		logic [DataW-1:0] operand_b;
		logic [ResW-1:0]  simple_res;
	} amf_item_t;

	localparam logic [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALL32 = 64'h0000_0000_FFFF_FFFF;

	function automatic logic [31:0] ln_edge(input logic [4:0] i);
		logic [31:0] e;
		begin
			unique case (i)
				5'd0: e = 32'd3;          5'd1: e = 32'd8;
				5'd2: e = 32'd21;         5'd3: e = 32'd55;
				5'd4: e = 32'd149;        5'd5: e = 32'd404;
				5'd6: e = 32'd1097;       5'd7: e = 32'd2981;
				5'd8: e = 32'd8104;       5'd9: e = 32'd22027;
				5'd10: e = 32'd59875;     5'd11: e = 32'd162755;
				5'd12: e = 32'd442414;    5'd13: e = 32'd1202605;
				5'd14: e = 32'd3269018;   5'd15: e = 32'd8886111;
				5'd16: e = 32'd24154953;  5'd17: e = 32'd65659970;
				5'd18: e = 32'd178482301; 5'd19: e = 32'd485165196;
				5'd20: e = 32'd1318815735; 5'd21: e = 32'd3584912847;
				default: e = 32'hFFFF_FFFF;
			endcase
			return e;
		end
	endfunction

	function automatic logic [31:0] pow10(input logic [3:0] i);
		logic [31:0] e;
		begin
			unique case (i)
				4'd1: e = 32'd10;         4'd2: e = 32'd100;
				4'd3: e = 32'd1000;       4'd4: e = 32'd10000;
				4'd5: e = 32'd100000;     4'd6: e = 32'd1000000;
				4'd7: e = 32'd10000000;   4'd8: e = 32'd100000000;
				4'd9: e = 32'd1000000000;
				default: e = 32'hFFFF_FFFF;
			endcase
			return e;
		end
	endfunction

	function automatic logic [63:0] exp_tab(input logic [5:0] k);
		logic [63:0] v;
		begin
			unique case (k)
				6'd0: v = 64'd1; 6'd1: v = 64'd2; 6'd2: v = 64'd7; 6'd3: v = 64'd20;
				6'd4: v = 64'd54; 6'd5: v = 64'd148; 6'd6: v = 64'd403;
				6'd7: v = 64'd1096; 6'd8: v = 64'd2980; 6'd9: v = 64'd8103;
				6'd10: v = 64'd22026; 6'd11: v = 64'd59874; 6'd12: v = 64'd162754;
				6'd13: v = 64'd442413; 6'd14: v = 64'd1202604; 6'd15: v = 64'd3269017;
				6'd16: v = 64'd8886110; 6'd17: v = 64'd24154952;
				6'd18: v = 64'd65659969; 6'd19: v = 64'd178482300;
				6'd20: v = 64'd485165195; 6'd21: v = 64'd1318815734;
				6'd22: v = 64'd3584912846; 6'd23: v = 64'd9744803446;
				6'd24: v = 64'd26489122129; 6'd25: v = 64'd72004899337;
				6'd26: v = 64'd195729609428; 6'd27: v = 64'd532048240601;
				6'd28: v = 64'd1446257064291; 6'd29: v = 64'd3931334297144;
				6'd30: v = 64'd10686474581524; 6'd31: v = 64'd29048849665247;
				6'd32: v = 64'd78962960182680; 6'd33: v = 64'd214643579785916;
				6'd34: v = 64'd583461742527454; 6'd35: v = 64'd1586013452313430;
				6'd36: v = 64'd4311231547115195; 6'd37: v = 64'd11719142372802611;
				6'd38: v = 64'd31855931757113756; 6'd39: v = 64'd86593400423993746;
				6'd40: v = 64'd235385266837019985; 6'd41: v = 64'd639843493530054949;
				6'd42: v = 64'd1739274941520501047;
				6'd43: v = 64'd4727839468229346561;
				default: v = SAT64;
			endcase
			return v;
		end
	endfunction
endpackage
`default_nettype wire

[rtl/amf_if.sv]
// ----------------------------------------------------------------------------
// amf_in_if / amf_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface amf_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source (output valid, action, operand_a, operand_b, input ready);
	modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface amf_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic [31:0] flag_word;
	modport source (output valid, result_value, flag_word, input ready);
	modport sink (input valid, result_value, flag_word, output ready);
endinterface
`default_nettype wire

[rtl/amf_front.sv]
// ----------------------------------------------------------------------------
// amf_front
// Accepts operation beats, classifies them and works out the results of the simple ops.
// ----------------------------------------------------------------------------
`default_nettype none
module amf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	amf_in_if.sink                  in_ch,
	output amf_pkg::amf_item_t      item,
	output logic                    item_valid,
	input  wire logic               item_ready
);
	import amf_pkg::*;

	logic [63:0] a64, b64, res;
	logic [4:0]  ln_k;
	logic [3:0]  lg_k;
	op_class_t   cls;

	assign a64 = {32'd0, in_ch.operand_a};
	assign b64 = {32'd0, in_ch.operand_b};

	// Threshold compares for the logs (independent compares, then a count)
	always_comb begin
		ln_k = '0;
		for (int i = 0; i < 22; i++) begin
			if (in_ch.operand_a >= ln_edge(5'(i))) ln_k = 5'(i + 1);
		end
		lg_k = '0;
		for (int i = 1; i < 10; i++) begin
			if (in_ch.operand_a >= pow10(4'(i))) lg_k = 4'(i);
		end
	end

	// Simple results and class
	always_comb begin
		cls = CL_SIMPLE;
		res = '0;
		unique case (in_ch.action)
			OP_ADD:   res = a64 + b64;
			OP_SUB:   res = a64 - b64;
			OP_INC:   res = a64 + 64'd1;
			OP_DEC:   res = a64 - 64'd1;
			OP_MUL:   cls = CL_MUL;
			OP_SQR:   cls = CL_MUL;
			OP_DIV:   cls = CL_DIV;
			OP_SQRT:  cls = CL_SQRT;
			OP_PASSA: res = a64;
			OP_PASSB: res = b64;
			OP_ZERO:  res = '0;
			OP_ONES:  res = ALL32;
			OP_LN:    res = (in_ch.operand_a == '0) ? ALL32 : {59'd0, ln_k};
			OP_LOG10: res = (in_ch.operand_a == '0) ? ALL32 : {60'd0, lg_k};
			OP_EXP:   res = (in_ch.operand_a < 32'd44) ?
				exp_tab(in_ch.operand_a[5:0]) : SAT64;
			OP_OR:    res = a64 | b64;
			OP_AND:   res = a64 & b64;
			OP_XOR:   res = a64 ^ b64;
			OP_NOT:   res = {32'd0, ~in_ch.operand_a};
			OP_SHR:   res = a64 >> 1;
			OP_SHL:   res = {32'd0, in_ch.operand_a[30:0], 1'b0};
			default:  res = '0;
		endcase
	end

	// Output register, reloads whenever empty or drained
	assign in_ch.ready = !item_valid || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (in_ch.ready) begin
			item_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item.cls        <= cls;
			item.action     <= in_ch.action;
			item.operand_a  <= in_ch.operand_a;
			item.operand_b  <= (in_ch.action == OP_SQR) ? in_ch.operand_a : in_ch.operand_b;
			item.simple_res <= res;
		end
	end
endmodule
`default_nettype wire

[rtl/amf_queue.sv]
// ----------------------------------------------------------------------------
// amf_queue
// Small FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none
module amf_queue #(
	parameter int unsigned Depth = amf_pkg::QueueDepthDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  amf_pkg::amf_item_t wr_item,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output amf_pkg::amf_item_t rd_item,
	output logic               rd_valid,
	input  wire logic          rd_ready
);
	import amf_pkg::*;
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	amf_item_t       mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end
endmodule
`default_nettype wire

[rtl/amf_back.sv]
// ----------------------------------------------------------------------------
// amf_back
// Pipelined execution: 32x32 multiply, restoring divide and square root,
// one bit per stage, then flag generation into an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alu_with_math_ops_and_flags_top_macros.svh"
module amf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  amf_pkg::amf_item_t item,
	input  wire logic          item_valid,
	output logic               item_ready,
	amf_out_if.source          out_ch
);
	import amf_pkg::*;
	localparam int unsigned NS = 32;

	typedef struct packed {
		op_class_t   cls;
		logic [4:0]  action;
		logic [31:0] b;
		logic [31:0] num;   // dividend / radicand bits still to shift in
		logic [32:0] rem;
		logic [31:0] quo;   // quotient or root bits
		logic [63:0] res;   // simple result or product
	} stg_t;

	stg_t st_s [NS+1];
	logic vld_s [NS+1];
	logic adv;
	logic [63:0] prod;

	// Whole pipeline moves together; stalls only when the output holds
	assign adv = !out_ch.valid || out_ch.ready;
	assign item_ready = adv;
	assign prod = 64'(item.operand_a) * 64'(item.operand_b);

	// Stage 0: combinational load; the product is formed here and registered by the first stage
	always_comb begin
		st_s[0].cls    = item.cls;
		st_s[0].action = item.action;
		st_s[0].b      = item.operand_b;
		st_s[0].num    = item.operand_a;
		st_s[0].rem    = '0;
		st_s[0].quo    = '0;
		st_s[0].res    = item.simple_res;
		vld_s[0]       = item_valid;
	end

	// Digit stages: divide takes one quotient bit per stage, sqrt one root
	// bit per stage from two radicand bits, so only the first 16 stages work.
	for (genvar g = 0; g < NS; g++) begin : g_stage
		stg_t nx;
		logic [33:0] trial;
		always_comb begin
			nx = st_s[g];
			trial = '0;
			if (g == 0 && st_s[g].cls == CL_MUL) begin
				nx.res = (prod > SAT64) ? SAT64 : prod;
			end
			if (st_s[g].cls == CL_DIV) begin
				trial = {st_s[g].rem, st_s[g].num[31]} - {2'b0, st_s[g].b};
				if (!trial[33]) begin
					nx.rem = trial[32:0];
					nx.quo = {st_s[g].quo[30:0], 1'b1};
				end else begin
					nx.rem = {st_s[g].rem[31:0], st_s[g].num[31]};
					nx.quo = {st_s[g].quo[30:0], 1'b0};
				end
				nx.num = {st_s[g].num[30:0], 1'b0};
			end else if (st_s[g].cls == CL_SQRT && g < 16) begin
				trial = {1'b0, st_s[g].rem[30:0], st_s[g].num[31:30]}
					- {st_s[g].quo[31:0], 2'b01};
				if (!trial[33]) begin
					nx.rem = trial[32:0];
					nx.quo = {st_s[g].quo[30:0], 1'b1};
				end else begin
					nx.rem = {st_s[g].rem[30:0], st_s[g].num[31:30]};
					nx.quo = {st_s[g].quo[30:0], 1'b0};
				end
				nx.num = {st_s[g].num[29:0], 2'b00};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) st_s[g+1] <= nx;
		end
	end

	// Result select and flags
	logic [63:0] r;
	logic [63:0] mag;
	logic [31:0] flg;
	always_comb begin
		unique case (st_s[NS].cls)
			CL_DIV:  r = (st_s[NS].b == '0) ? ALL32 : {32'd0, st_s[NS].quo};
			CL_SQRT: r = {32'd0, st_s[NS].quo};
			default: r = st_s[NS].res;
		endcase
		mag = r[63] ? (64'd0 - r) : r;
		flg = {28'd0, (r == '0), (mag > ALL32), r[63], ^r[32:0]};
		if (st_s[NS].action == OP_PASSB) flg = st_s[NS].b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.result_value <= r;
			out_ch.flag_word    <= flg;
		end
	end

	`AMF_ASSERT_NXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
		"result beat dropped while stalled")
	`AMF_ASSERT_IMP(a_sat, clk, arst_n, out_ch.valid && out_ch.result_value[63],
		out_ch.flag_word[1],
		"sign flag mismatch")
	`AMF_ASSERT_NXT(a_flow, clk, arst_n, adv && vld_s[NS], out_ch.valid,
		"finished item not presented")
endmodule
`default_nettype wire

[rtl/alu_with_math_ops_and_flags_top.sv]
// ----------------------------------------------------------------------------
// alu_with_math_ops_and_flags_top
// Integer ALU with status flags.
// ----------------------------------------------------------------------------
// Takes one operation beat per cycle unless the queue is full. Each result
// passes through the front register, which loads at the accepting edge, the
// queue, 32 one-bit divide/root stages (the multiplier feeds the first) and
// the output register. The back pipeline advances as one and holds while a
// result waits; the queue (QueueDepth, default 4) decouples the front end.
`default_nettype none
module alu_with_math_ops_and_flags_top #(
	parameter int unsigned QueueDepth = amf_pkg::QueueDepthDef
) (
	input wire logic  clk,
	input wire logic  arst_n,
	amf_in_if.sink    in_ch,
	amf_out_if.source out_ch
);
	import amf_pkg::*;

	amf_item_t f_item, q_item;
	logic      f_valid, f_ready, q_valid, q_ready;

	amf_front u_front (.clk, .arst_n, .in_ch, .item(f_item), .item_valid(f_valid),
		.item_ready(f_ready));

	amf_queue #(.Depth(QueueDepth)) u_queue (.clk, .arst_n, .wr_item(f_item),
		.wr_valid(f_valid), .wr_ready(f_ready), .rd_item(q_item),
		.rd_valid(q_valid), .rd_ready(q_ready));

	amf_back u_back (.clk, .arst_n, .item(q_item), .item_valid(q_valid),
		.item_ready(q_ready), .out_ch);
endmodule
`default_nettype wire
